@@ src/fpa_pkg.sv @@
// Shared types and constants of the fixed-point ALU.
package fpa_pkg;

  localparam int RAW_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int FRAC_MAX     = 30;
  // Divider numerator: the dividend magnitude with room for the largest fraction
  localparam int NUM_W        = RAW_WIDTH + FRAC_MAX;
  localparam int PROD_W       = 2 * RAW_WIDTH;
  localparam int MAG_W        = PROD_W - 1;

  localparam logic [RAW_WIDTH-1:0] POS_MAX = {1'b0, {(RAW_WIDTH-1){1'b1}}};
  localparam logic [RAW_WIDTH-1:0] NEG_MIN = {1'b1, {(RAW_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MAX      = 4'd4,
    OP_MIN      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_GT       = 4'd10,
    OP_LT       = 4'd11,
    OP_GE       = 4'd12,
    OP_LE       = 4'd13,
    OP_EQ       = 4'd14,
    OP_NE       = 4'd15
  } op_t;

  // One request as it travels down the pipeline
  typedef struct packed {
    op_t                  op;
    logic [RAW_WIDTH-1:0] res;
    logic                 cmp;
    logic                 neg;
    logic                 dz;
    logic [RAW_WIDTH-1:0] ma;
    logic [RAW_WIDTH-1:0] mb;
    logic [PROD_W-1:0]    prod;
    logic [RAW_WIDTH:0]   rem;
    logic [NUM_W-1:0]     quo;
    logic [NUM_W-1:0]     num;
    logic [MAG_W-1:0]     mag;
  } pipe_t;

endpackage

@@ src/fpa_if.sv @@
// Request and result channel interfaces of the fixed-point ALU.
interface fpa_in_if;
  logic                                valid;
  logic                                ready;
  logic [3:0]                          opcode;
  logic signed [fpa_pkg::RAW_WIDTH-1:0] operand_a;
  logic signed [fpa_pkg::RAW_WIDTH-1:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpa_pkg::RAW_WIDTH-1:0] result_raw;
  logic                                compare_true;
  logic                                overflowed;
  logic                                divide_by_zero;
  modport source (output valid, result_raw, compare_true, overflowed, divide_by_zero,
                  input ready);
  modport sink (input valid, result_raw, compare_true, overflowed, divide_by_zero,
                output ready);
endinterface

@@ src/fpa_front.sv @@
// Decode stage: simple operations, comparisons, magnitudes and divider setup.
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [3:0]                           opcode,
  input  logic signed [fpa_pkg::RAW_WIDTH-1:0] operand_a,
  input  logic signed [fpa_pkg::RAW_WIDTH-1:0] operand_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fpa_pkg::pipe_t                       out_item
);
  import fpa_pkg::*;

  op_t                  op;
  logic                 a_gt_b;
  logic                 b_gt_a;
  logic [RAW_WIDTH-1:0] ma;
  logic [RAW_WIDTH-1:0] mb;
  pipe_t                item_next;
  logic                 vld;
  pipe_t                item;

  // Decode and compute everything that needs no wide arithmetic
  always_comb begin
    op     = op_t'(opcode);
    a_gt_b = operand_a > operand_b;
    b_gt_a = operand_b > operand_a;
    ma     = operand_a[RAW_WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
    mb     = operand_b[RAW_WIDTH-1] ? (~operand_b + 1'b1) : operand_b;

    item_next      = '0;
    item_next.op   = op;
    item_next.neg  = operand_a[RAW_WIDTH-1] ^ operand_b[RAW_WIDTH-1];
    item_next.ma   = ma;
    item_next.mb   = mb;
    item_next.num  = {ma, {(NUM_W-RAW_WIDTH){1'b0}}};
    item_next.dz   = (op == OP_DIV) && (operand_b == '0);

    case (op)
      OP_ADD:      item_next.res = operand_a + operand_b;
      OP_SUB:      item_next.res = operand_a - operand_b;
      OP_DIV:      item_next.res = operand_a[RAW_WIDTH-1] ? NEG_MIN : POS_MAX;
      OP_MAX:      item_next.res = a_gt_b ? operand_a : operand_b;
      OP_MIN:      item_next.res = b_gt_a ? operand_a : operand_b;
      OP_INC:      item_next.res = operand_a + 1'b1;
      OP_DEC:      item_next.res = operand_a - 1'b1;
      OP_FROM_INT: item_next.res = operand_a <<< FRAC_BITS;
      OP_TO_INT:   item_next.res = operand_a >>> FRAC_BITS;
      default:     item_next.res = '0;
    endcase

    case (op)
      OP_GT:   item_next.cmp = a_gt_b;
      OP_LT:   item_next.cmp = b_gt_a;
      OP_GE:   item_next.cmp = !b_gt_a;
      OP_LE:   item_next.cmp = !a_gt_b;
      OP_EQ:   item_next.cmp = operand_a == operand_b;
      OP_NE:   item_next.cmp = operand_a != operand_b;
      default: item_next.cmp = 1'b0;
    endcase
  end

  assign in_ready = !vld || out_ready;

  // Advance when the next stage takes our request or we are empty
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = vld;
  assign out_item  = item;
endmodule

@@ src/fpa_mul.sv @@
// Multiply stage: full product of the operand magnitudes.
module fpa_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::pipe_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::pipe_t out_item
);
  import fpa_pkg::*;

  pipe_t item_next;
  logic  vld;
  pipe_t item;

  // Form the unsigned product
  always_comb begin
    item_next      = in_item;
    item_next.prod = PROD_W'(in_item.ma) * PROD_W'(in_item.mb);
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = vld;
  assign out_item  = item;
endmodule

@@ src/fpa_div_step.sv @@
// Divider stage: a few restoring division steps on the magnitudes.
module fpa_div_step #(
  parameter int STEPS = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::pipe_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::pipe_t out_item
);
  import fpa_pkg::*;

  pipe_t              item_next;
  logic [RAW_WIDTH:0] rs;
  logic [RAW_WIDTH:0] dv;
  logic [NUM_W-1:0]   nm;
  logic [NUM_W-1:0]   qu;
  logic               vld;
  pipe_t              item;

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    rs = in_item.rem;
    nm = in_item.num;
    qu = in_item.quo;
    dv = {1'b0, in_item.mb};
    for (int s = 0; s < STEPS; s++) begin
      rs = {rs[RAW_WIDTH-1:0], nm[NUM_W-1]};
      nm = nm << 1;
      qu = qu << 1;
      if (rs >= dv) begin
        rs    = rs - dv;
        qu[0] = 1'b1;
      end
    end
    item_next     = in_item;
    item_next.rem = rs;
    item_next.num = nm;
    item_next.quo = qu;
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = vld;
  assign out_item  = item;
endmodule

@@ src/fpa_round.sv @@
// Rounding stage: round product and quotient magnitudes to nearest.
module fpa_round #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::pipe_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::pipe_t out_item
);
  import fpa_pkg::*;

  localparam logic [PROD_W-1:0] BIAS = PROD_W'(1) << (FRAC_BITS - 1);

  pipe_t             item_next;
  logic [PROD_W-1:0] biased;
  logic [RAW_WIDTH:0] half_gap;
  logic              round_up;
  logic              vld;
  pipe_t             item;

  // Ties go away from zero: the magnitude rounds up on an exact half
  always_comb begin
    biased    = in_item.prod + BIAS;
    half_gap  = {1'b0, in_item.mb} - in_item.rem;
    round_up  = in_item.rem >= half_gap;
    item_next = in_item;
    case (in_item.op)
      OP_MUL:  item_next.mag = MAG_W'(biased >> FRAC_BITS);
      OP_DIV:  item_next.mag = MAG_W'(in_item.quo) + MAG_W'(round_up);
      default: item_next.mag = '0;
    endcase
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = vld;
  assign out_item  = item;
endmodule

@@ src/fpa_sat.sv @@
// Output stage: saturate, apply the sign and hold the result register.
module fpa_sat (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpa_pkg::pipe_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpa_pkg::RAW_WIDTH-1:0] result_raw,
  output logic                          compare_true,
  output logic                          overflowed,
  output logic                          divide_by_zero
);
  import fpa_pkg::*;

  logic [MAG_W-1:0]     limit;
  logic                 over;
  logic [RAW_WIDTH-1:0] sel;
  logic [RAW_WIDTH-1:0] res_next;
  logic                 ovf_next;
  logic                 vld;
  logic [RAW_WIDTH-1:0] res;
  logic                 cmp;
  logic                 ovf;
  logic                 dz;

  // Clamp the magnitude to the signed range and negate where needed
  always_comb begin
    limit = in_item.neg ? MAG_W'(NEG_MIN) : MAG_W'(POS_MAX);
    over  = in_item.mag > limit;
    sel   = over ? limit[RAW_WIDTH-1:0] : in_item.mag[RAW_WIDTH-1:0];
    if ((in_item.op == OP_MUL || in_item.op == OP_DIV) && !in_item.dz) begin
      res_next = in_item.neg ? (~sel + 1'b1) : sel;
      ovf_next = over;
    end else begin
      res_next = in_item.res;
      ovf_next = 1'b0;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
      cmp <= in_item.cmp;
      ovf <= ovf_next;
      dz  <= in_item.dz;
    end
  end

  assign out_valid      = vld;
  assign result_raw     = res;
  assign compare_true   = cmp;
  assign overflowed     = ovf;
  assign divide_by_zero = dz;
endmodule

@@ src/fixed_point_alu.sv @@
// Top level of the pipelined signed fixed-point ALU.
//
//   channel   | dir | payload
//   operands  | in  | opcode, operand_a, operand_b
//   results   | out | result_raw, compare_true, overflowed, divide_by_zero
//
// One request enters per cycle unless a stall holds the pipeline. Its stages are
// decode, multiply, two divider bits per stage, round, saturate; the divider
// chain sets the depth. Every operation takes the same path, so results leave
// in order. Reset clears all stage valid bits. A stall on the result side
// lets empty stages fill while full stages hold; nothing is lost.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fpa_in_if.sink    operands,
  fpa_out_if.source results
);
  import fpa_pkg::*;

  localparam int NUM_STEPS = RAW_WIDTH + FRAC_BITS;
  localparam int DIV_STG   = (NUM_STEPS + 1) / 2;
  localparam int LAST      = DIV_STG + 2;

  // Stage k output: 0 decode, 1 multiply, 2..DIV_STG+1 divider, LAST round
  pipe_t item [0:LAST];
  logic  vld  [0:LAST];
  logic  rdy  [0:LAST];

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .opcode    (operands.opcode),
    .operand_a (operands.operand_a),
    .operand_b (operands.operand_b),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_item  (item[0])
  );

  fpa_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[0]),
    .in_ready  (rdy[0]),
    .in_item   (item[0]),
    .out_valid (vld[1]),
    .out_ready (rdy[1]),
    .out_item  (item[1])
  );

  // Divider chain, two quotient bits per stage, one in the last if odd
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    fpa_div_step #(.STEPS((NUM_STEPS - 2 * k >= 2) ? 2 : 1)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k+1]),
      .in_ready  (rdy[k+1]),
      .in_item   (item[k+1]),
      .out_valid (vld[k+2]),
      .out_ready (rdy[k+2]),
      .out_item  (item[k+2])
    );
  end

  fpa_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[LAST-1]),
    .in_ready  (rdy[LAST-1]),
    .in_item   (item[LAST-1]),
    .out_valid (vld[LAST]),
    .out_ready (rdy[LAST]),
    .out_item  (item[LAST])
  );

  fpa_sat u_sat (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (vld[LAST]),
    .in_ready       (rdy[LAST]),
    .in_item        (item[LAST]),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .result_raw     (results.result_raw),
    .compare_true   (results.compare_true),
    .overflowed     (results.overflowed),
    .divide_by_zero (results.divide_by_zero)
  );

`ifndef SYNTHESIS
  // A zero divisor saturates without the overflow flag
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.overflowed && results.divide_by_zero))
    else $error("overflow and divide-by-zero raised together");

  // Comparisons return a zero raw word
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.compare_true) |-> (results.result_raw == '0))
    else $error("comparison result with nonzero raw word");

  // An empty decode stage always takes a request
  a_front_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> operands.ready)
    else $error("decode stage empty but not ready");

  // Only a divide can flag a zero divisor in the rounding stage
  a_dz_div_only: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && item[LAST].dz) |-> (item[LAST].op == OP_DIV))
    else $error("zero divisor flag on a non-divide request");
`endif
endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the pipelined fixed-point ALU.
`timescale 1ns / 100ps

module tb_top;
  import fpa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = (32 + FRAC + 1) / 2 + 4;

  typedef struct {
    op_t                    op;
    logic signed [31:0]     a;
    logic signed [31:0]     b;
  } alu_req_t;

  typedef struct {
    logic [31:0] raw;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fixed_point_alu dut (
    .clk      (clk),
    .rst      (rst),
    .operands (in_ch),
    .results  (out_ch)
  );

  always #4 clk = ~clk;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       sent_cnt = 0;
  int       total_reqs = 0;
  int       err_cnt = 0;
  logic     hold_off = 1'b0;

  // Print one mismatch line and count it
  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %h got %h (t=%0t)", what, want, got, $realtime);
    err_cnt++;
  endtask

  // Clamp a rounded magnitude to the raw range and apply the sign
  function automatic alu_res_t saturate(input logic [63:0] mag, input logic neg);
    alu_res_t r;
    logic [63:0] limit;
    r = '{default: 0};
    limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (mag > limit) begin
      mag = limit;
      r.ovf = 1'b1;
    end
    r.raw = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    return r;
  endfunction

  // Compute the expected ALU result of one request
  function automatic alu_res_t alu_predict(input alu_req_t q);
    alu_res_t    r;
    logic signed [63:0] p;
    logic [63:0] mag, d, num, quo, rem;
    logic        neg;
    r = '{default: 0};
    neg = q.a[31] ^ q.b[31];
    case (q.op)
      OP_ADD:      r.raw = q.a + q.b;
      OP_SUB:      r.raw = q.a - q.b;
      OP_MUL: begin
        p = 64'(q.a) * 64'(q.b);
        mag = p[63] ? -p : p;
        mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        r = saturate(mag, neg);
      end
      OP_DIV: begin
        if (q.b == 0) begin
          r.dz = 1'b1;
          r.raw = q.a[31] ? NEG_MIN : POS_MAX;
        end else begin
          mag = q.a[31] ? -64'(q.a) : 64'(q.a);
          d = q.b[31] ? -64'(q.b) : 64'(q.b);
          num = mag << FRAC;
          quo = num / d;
          rem = num % d;
          if (rem >= d - rem) quo++;
          r = saturate(quo, neg);
        end
      end
      OP_MAX:      r.raw = (q.a > q.b) ? q.a : q.b;
      OP_MIN:      r.raw = (q.b > q.a) ? q.a : q.b;
      OP_INC:      r.raw = q.a + 32'sd1;
      OP_DEC:      r.raw = q.a - 32'sd1;
      OP_FROM_INT: r.raw = q.a << FRAC;
      OP_TO_INT:   r.raw = q.a >>> FRAC;
      OP_GT:       r.cmp = q.a > q.b;
      OP_LT:       r.cmp = q.a < q.b;
      OP_GE:       r.cmp = q.a >= q.b;
      OP_LE:       r.cmp = q.a <= q.b;
      OP_EQ:       r.cmp = q.a == q.b;
      default:     r.cmp = q.a != q.b;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h100, 32'hffff_ff00, 32'h80};
    case ($urandom_range(0, 3))
      0:       return specials[$urandom_range(0, 7)];
      1:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input op_t op, input logic [31:0] a, input logic [31:0] b);
    pending_reqs.push_back('{op, a, b});
  endtask

  // Fill the request queue: directed corners, then random requests
  initial begin
    alu_req_t q;
    add_req(OP_ADD, 32'h7fff_ffff, 32'h1);
    add_req(OP_SUB, 32'h8000_0000, 32'h1);
    add_req(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_req(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    add_req(OP_MUL, 32'h8000_0000, 32'h100);
    add_req(OP_MUL, 32'h1, 32'h80);
    add_req(OP_MUL, 32'hffff_ffff, 32'h80);
    add_req(OP_DIV, 32'h500, 32'h0);
    add_req(OP_DIV, 32'hffff_fb00, 32'h0);
    add_req(OP_DIV, 32'h0, 32'h0);
    add_req(OP_DIV, 32'h8000_0000, 32'h100);
    add_req(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    add_req(OP_DIV, 32'h1, 32'h200);
    add_req(OP_DIV, 32'h7fff_ffff, 32'h1);
    add_req(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    add_req(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    add_req(OP_INC, 32'h7fff_ffff, 32'hdead_beef);
    add_req(OP_DEC, 32'h8000_0000, 32'h1234_5678);
    add_req(OP_FROM_INT, 32'h00ff_ffff, 32'h0);
    add_req(OP_TO_INT, 32'hffff_ff7f, 32'h0);
    add_req(OP_GT, 32'h5, 32'h5);
    add_req(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    add_req(OP_GE, 32'h5, 32'h5);
    add_req(OP_LE, 32'h7fff_ffff, 32'h8000_0000);
    add_req(OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
    add_req(OP_NE, 32'h0, 32'h0);
    repeat (650) begin
      q.op = op_t'($urandom_range(0, 15));
      q.a = pick_operand();
      q.b = ($urandom_range(0, 5) == 0) ? q.a : pick_operand();
      pending_reqs.push_back(q);
    end
    total_reqs = pending_reqs.size();
  end

  // Idle percentage of each phase: none, sender, receiver, both
  function automatic int src_idle_pct(input int n);
    int ph;
    ph = (total_reqs == 0) ? 0 : (n * 4) / total_reqs;
    return (ph == 1) ? 54 : (ph == 3) ? 33 : 0;
  endfunction

  function automatic int snk_stall_pct(input int n);
    int ph;
    ph = (total_reqs == 0) ? 0 : (n * 4) / total_reqs;
    return (ph == 2) ? 54 : (ph == 3) ? 33 : 0;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: record accepted requests, then offer the next one
  always @(posedge clk) begin
    alu_req_t q;
    logic     busy;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      busy = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(alu_predict('{op_t'(in_ch.opcode), in_ch.operand_a,
                                                 in_ch.operand_b}));
        sent_cnt++;
      end
      if (!busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct(sent_cnt)) begin
          q = pending_reqs.pop_front();
          in_ch.opcode <= q.op;
          in_ch.operand_a <= q.a;
          in_ch.operand_b <= q.b;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver for a long stretch so the pipeline backs up
  initial begin
    int cnt;
    wait (sent_cnt >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    for (cnt = 0; cnt < 200; cnt++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    alu_res_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 32'h0, out_ch.result_raw);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_raw !== want.raw) report("result_raw", want.raw, out_ch.result_raw);
          if (out_ch.compare_true !== want.cmp)
            report("compare_true", 32'(want.cmp), 32'(out_ch.compare_true));
          if (out_ch.overflowed !== want.ovf)
            report("overflowed", 32'(want.ovf), 32'(out_ch.overflowed));
          if (out_ch.divide_by_zero !== want.dz)
            report("divide_by_zero", 32'(want.dz), 32'(out_ch.divide_by_zero));
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_stall_pct(sent_cnt));
    end
  end

  // Drain, then give the verdict
  initial begin
    wait (!rst && total_reqs > 0);
    wait (pending_reqs.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ fixed_point_alu.f @@
src/fpa_pkg.sv
src/fpa_if.sv
src/fpa_front.sv
src/fpa_mul.sv
src/fpa_div_step.sv
src/fpa_round.sv
src/fpa_sat.sv
src/fixed_point_alu.sv
tb/sv/tb_top.sv
